// File: design/char_lcd_4bit_write_controller_core_macros.svh
// ----------------------------------------------------------------------------
// Character LCD write controller: assertion macros
// Shared helpers for the concurrent checks of the LCD controller.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_4BIT_WRITE_CONTROLLER_CORE_MACROS_SVH
`define CHAR_LCD_4BIT_WRITE_CONTROLLER_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define LCD4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside of reset.
`define LCD4_ASSERT_NEVER(lbl, cond, msg) \
  `LCD4_ASSERT(lbl, !(cond), msg)

`endif

// File: design/lcd4_pkg.sv
// ----------------------------------------------------------------------------
// LCD controller package
// Widths, register indexes, reset values, item types and helper functions.
// ----------------------------------------------------------------------------
package lcd4_pkg;

  localparam int unsigned ActionW  = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned NibW     = 4;
  localparam int unsigned WaitW    = 20;
  localparam int unsigned PulseW   = 10;
  localparam int unsigned SettleW  = 16;
  localparam int unsigned PowerW   = 20;
  localparam int unsigned GapW     = 16;
  localparam int unsigned StepW    = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  localparam int unsigned DefaultQueueDepth = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_PULSE    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CMD_WAIT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DAT_WAIT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_POWER_UP = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INIT_GAP = 3'd4;

  // Register values after reset.
  localparam logic [PulseW-1:0]  RST_PULSE    = 10'd50;
  localparam logic [SettleW-1:0] RST_CMD_WAIT = 16'd2000;
  localparam logic [SettleW-1:0] RST_DAT_WAIT = 16'd50;
  localparam logic [PowerW-1:0]  RST_POWER_UP = 20'd500000;
  localparam logic [GapW-1:0]    RST_INIT_GAP = 16'd5000;

  // Init sequence bookkeeping.
  localparam logic [StepW-1:0] STEP_IDLE      = 4'd0;
  localparam logic [StepW-1:0] STEP_FIRST_NIB = 4'd1;
  localparam logic [StepW-1:0] STEP_LAST_NIB  = 4'd4;
  localparam logic [StepW-1:0] STEP_FIRST_CMD = 4'd5;
  localparam logic [StepW-1:0] STEP_LAST_CMD  = 4'd9;

  localparam logic [NibW-1:0] NIB_WAKE = 4'h3;
  localparam logic [NibW-1:0] NIB_4BIT = 4'h2;

  typedef enum logic [ActionW-1:0] {
    ACT_TICK = 2'd0,
    ACT_INIT = 2'd1,
    ACT_CMD  = 2'd2,
    ACT_DATA = 2'd3
  } lcd4_action_e;

  typedef struct packed {
    lcd4_action_e     kind;
    logic             is_req;
    logic [ByteW-1:0] byte_value;
  } lcd4_item_t;

  typedef struct packed {
    logic [PulseW-1:0]  pulse_ticks;
    logic [SettleW-1:0] command_wait_ticks;
    logic [SettleW-1:0] data_wait_ticks;
    logic [PowerW-1:0]  power_up_ticks;
    logic [GapW-1:0]    init_gap_ticks;
  } lcd4_cfg_t;

  // Commands sent during the init sequence, by step number.
  function automatic logic [ByteW-1:0] init_cmd(input logic [StepW-1:0] step);
    logic [ByteW-1:0] cmd;
    case (step)
      4'd5:    cmd = 8'h28;
      4'd6:    cmd = 8'h08;
      4'd7:    cmd = 8'h01;
      4'd8:    cmd = 8'h06;
      4'd9:    cmd = 8'h0F;
      default: cmd = 8'h00;
    endcase
    return cmd;
  endfunction

  // A phase of d ticks reloads the counter with d-1; zero acts as one.
  function automatic logic [WaitW-1:0] span(input logic [WaitW-1:0] d);
    logic [WaitW-1:0] r;
    r = (d == '0) ? '0 : d - 1'b1;
    return r;
  endfunction

endpackage

// File: design/lcd4_in_if.sv
// ----------------------------------------------------------------------------
// LCD controller request channel
// Valid/ready channel carrying one action and its byte per item.
// ----------------------------------------------------------------------------
interface lcd4_in_if;
  import lcd4_pkg::*;

  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [ByteW-1:0]   byte_value;

  modport source (output valid, output action, output byte_value, input ready);
  modport sink   (input valid, input action, input byte_value, output ready);
endinterface

// File: design/lcd4_out_if.sv
// ----------------------------------------------------------------------------
// LCD controller pin-state channel
// Valid/ready channel carrying the pin levels and status of one tick.
// ----------------------------------------------------------------------------
interface lcd4_out_if;
  import lcd4_pkg::*;

  logic            valid;
  logic            ready;
  logic            reg_select;
  logic            read_write;
  logic            enable;
  logic [NibW-1:0] bus_nibble;
  logic            busy_res;
  logic            rejected;

  modport source (output valid, output reg_select, output read_write, output enable,
                  output bus_nibble, output busy_res, output rejected, input ready);
  modport sink   (input valid, input reg_select, input read_write, input enable,
                  input bus_nibble, input busy_res, input rejected, output ready);
endinterface

// File: design/char_lcd_4bit_write_controller_core.sv
// ----------------------------------------------------------------------------
// Character LCD 4-bit write controller
// Top level: configuration registers, request front end and pin sequencer.
// ----------------------------------------------------------------------------
// Every item on in_i is one microsecond tick of an HD44780-style display
// controller, and every item yields exactly one item on out_o with the pin
// levels (RS, RW, EN, DB7..DB4) and status for that tick. An action of init
// runs the power-up wait and the full 4-bit wake-up and setup sequence, and
// command or data actions send one byte as two enable-strobed nibbles
// followed by a settle time. A request that arrives while a sequence runs is
// dropped and flagged as rejected, but it still counts as a tick. The block
// takes one item per clock cycle while out_o does not stall: the sequencer
// in the back end advances its phase and countdown once per item. An item
// is written into the queue when it is accepted, and the sequencer
// registers its pin levels when it takes the item from the queue, so its
// result on out_o is registered. The queue lets the input keep flowing for
// up to Depth items while out_o stalls.
// The user must write timing registers through cfg_we_i, cfg_idx_i and
// cfg_wdata_i only while no item is in flight; the block does not enforce
// this. Indexes past the last register are ignored.
// ----------------------------------------------------------------------------
module char_lcd_4bit_write_controller_core #(
  parameter int unsigned QueueDepth = lcd4_pkg::DefaultQueueDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lcd4_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lcd4_pkg::CfgDataW-1:0]  cfg_wdata_i,
  lcd4_in_if.sink                        in_i,
  lcd4_out_if.source                     out_o
);
  import lcd4_pkg::*;

  lcd4_cfg_t  cfg_q;
  logic       deq_valid;
  logic       deq_ready;
  lcd4_item_t deq_item;

  // Timing registers. A write to an unknown index changes nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_ticks        <= RST_PULSE;
      cfg_q.command_wait_ticks <= RST_CMD_WAIT;
      cfg_q.data_wait_ticks    <= RST_DAT_WAIT;
      cfg_q.power_up_ticks     <= RST_POWER_UP;
      cfg_q.init_gap_ticks     <= RST_INIT_GAP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PULSE:    cfg_q.pulse_ticks        <= cfg_wdata_i[PulseW-1:0];
        CFG_CMD_WAIT: cfg_q.command_wait_ticks <= cfg_wdata_i[SettleW-1:0];
        CFG_DAT_WAIT: cfg_q.data_wait_ticks    <= cfg_wdata_i[SettleW-1:0];
        CFG_POWER_UP: cfg_q.power_up_ticks     <= cfg_wdata_i[PowerW-1:0];
        CFG_INIT_GAP: cfg_q.init_gap_ticks     <= cfg_wdata_i[GapW-1:0];
        default: ;
      endcase
    end
  end

  // Front end: takes items, classifies them and queues them.
  lcd4_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .deq_valid_o (deq_valid),
    .deq_ready_i (deq_ready),
    .deq_item_o  (deq_item)
  );

  // Back end: one sequencer tick per dequeued item, registered pin levels.
  lcd4_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .deq_valid_i (deq_valid),
    .deq_ready_o (deq_ready),
    .deq_item_i  (deq_item),
    .cfg_i       (cfg_q),
    .out_o       (out_o)
  );

endmodule

// File: design/lcd4_front.sv
// ----------------------------------------------------------------------------
// LCD controller front end
// Accepts items, classifies the action and queues them for the sequencer.
// ----------------------------------------------------------------------------
module lcd4_front #(
  parameter int unsigned Depth = lcd4_pkg::DefaultQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lcd4_in_if.sink             in_i,
  output logic                deq_valid_o,
  input  logic                deq_ready_i,
  output lcd4_pkg::lcd4_item_t deq_item_o
);
  import lcd4_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lcd4_item_t          item;
  lcd4_item_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                push, pop;

  // Classify the action; anything but a tick is a request.
  always_comb begin
    item.kind       = lcd4_action_e'(in_i.action);
    item.byte_value = in_i.byte_value;
    unique case (item.kind)
      ACT_TICK:                    item.is_req = 1'b0;
      ACT_INIT, ACT_CMD, ACT_DATA: item.is_req = 1'b1;
      default:                     item.is_req = 1'b0;
    endcase
  end

  assign in_i.ready  = (cnt_q != CntW'(Depth));
  assign deq_valid_o = (cnt_q != '0);
  assign deq_item_o  = mem_q[rd_ptr_q];
  assign push        = in_i.valid && in_i.ready;
  assign pop         = deq_valid_o && deq_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

// File: design/lcd4_back.sv
// ----------------------------------------------------------------------------
// LCD controller back end
// Pin sequencer that advances one tick per item, with a registered output.
// ----------------------------------------------------------------------------
module lcd4_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 deq_valid_i,
  output logic                 deq_ready_o,
  input  lcd4_pkg::lcd4_item_t deq_item_i,
  input  lcd4_pkg::lcd4_cfg_t  cfg_i,
  lcd4_out_if.source           out_o
);
  import lcd4_pkg::*;

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_POWER     = 4'd1;
  localparam logic [3:0] PH_NIB_PULSE = 4'd2;
  localparam logic [3:0] PH_NIB_GAP   = 4'd3;
  localparam logic [3:0] PH_HI_PULSE  = 4'd4;
  localparam logic [3:0] PH_LO_SETUP  = 4'd5;
  localparam logic [3:0] PH_LO_PULSE  = 4'd6;
  localparam logic [3:0] PH_SETTLE    = 4'd7;
  localparam logic [3:0] PH_INIT_GAP  = 4'd8;

  logic [3:0]       phase_q, phase_d, target;
  logic [WaitW-1:0] wait_q, wait_d;
  logic [ByteW-1:0] held_q, held_d;
  logic             sel_q, sel_d;
  logic [StepW-1:0] step_q, step_d;
  logic [NibW-1:0]  nib_q, nib_d;
  logic             en_q, en_d;
  logic             rej;
  logic             do_enter;
  logic             pop;
  logic             out_valid_q;
  logic             rej_q;
  logic             busy_q;

  logic [WaitW-1:0] pulse_span, gap_span, power_span, cmd_span, dat_span;

  assign pulse_span = span(WaitW'(cfg_i.pulse_ticks));
  assign gap_span   = span(WaitW'(cfg_i.init_gap_ticks));
  assign power_span = span(WaitW'(cfg_i.power_up_ticks));
  assign cmd_span   = span(WaitW'(cfg_i.command_wait_ticks));
  assign dat_span   = span(WaitW'(cfg_i.data_wait_ticks));

  // One tick of the sequencer: count down, or move on to the next phase.
  always_comb begin
    phase_d  = phase_q;
    wait_d   = wait_q;
    held_d   = held_q;
    sel_d    = sel_q;
    step_d   = step_q;
    nib_d    = nib_q;
    en_d     = en_q;
    rej      = 1'b0;
    do_enter = 1'b0;
    target   = PH_IDLE;

    if (phase_q != PH_IDLE) begin
      rej = deq_item_i.is_req;
      if (wait_q != '0) begin
        wait_d = wait_q - 1'b1;
      end else begin
        do_enter = 1'b1;
        unique case (phase_q)
          PH_POWER: begin
            step_d = STEP_FIRST_NIB;
            target = PH_NIB_PULSE;
          end
          PH_NIB_PULSE: target = PH_NIB_GAP;
          PH_NIB_GAP: begin
            if (step_q < STEP_LAST_NIB) begin
              step_d = step_q + 1'b1;
              target = PH_NIB_PULSE;
            end else begin
              step_d = STEP_FIRST_CMD;
              held_d = init_cmd(STEP_FIRST_CMD);
              sel_d  = 1'b0;
              target = PH_HI_PULSE;
            end
          end
          PH_HI_PULSE: target = PH_LO_SETUP;
          PH_LO_SETUP: target = PH_LO_PULSE;
          PH_LO_PULSE: target = PH_SETTLE;
          PH_SETTLE: begin
            if (step_q >= STEP_FIRST_CMD && step_q < STEP_LAST_CMD) begin
              target = PH_INIT_GAP;
            end else begin
              step_d = STEP_IDLE;
              target = PH_IDLE;
            end
          end
          PH_INIT_GAP: begin
            step_d = step_q + 1'b1;
            held_d = init_cmd(step_q + 1'b1);
            target = PH_HI_PULSE;
          end
          default: begin
            step_d = STEP_IDLE;
            target = PH_IDLE;
          end
        endcase
      end
    end else begin
      unique case (deq_item_i.kind)
        ACT_INIT: begin
          sel_d    = 1'b0;
          step_d   = STEP_IDLE;
          target   = PH_POWER;
          do_enter = 1'b1;
        end
        ACT_CMD, ACT_DATA: begin
          held_d   = deq_item_i.byte_value;
          sel_d    = (deq_item_i.kind == ACT_DATA);
          step_d   = STEP_IDLE;
          target   = PH_HI_PULSE;
          do_enter = 1'b1;
        end
        default: ;
      endcase
    end

    // Entry actions of the phase being entered.
    if (do_enter) begin
      phase_d = target;
      unique case (target)
        PH_POWER: begin
          en_d   = 1'b0;
          nib_d  = '0;
          wait_d = power_span;
        end
        PH_NIB_PULSE: begin
          nib_d  = (step_d == STEP_LAST_NIB) ? NIB_4BIT : NIB_WAKE;
          en_d   = 1'b1;
          wait_d = pulse_span;
        end
        PH_NIB_GAP, PH_INIT_GAP: begin
          en_d   = 1'b0;
          wait_d = gap_span;
        end
        PH_HI_PULSE: begin
          nib_d  = held_d[ByteW-1:NibW];
          en_d   = 1'b1;
          wait_d = pulse_span;
        end
        PH_LO_SETUP: begin
          nib_d  = held_d[NibW-1:0];
          en_d   = 1'b0;
          wait_d = '0;
        end
        PH_LO_PULSE: begin
          en_d   = 1'b1;
          wait_d = pulse_span;
        end
        PH_SETTLE: begin
          en_d   = 1'b0;
          wait_d = sel_d ? dat_span : cmd_span;
        end
        default: begin
          phase_d = PH_IDLE;
          en_d    = 1'b0;
          wait_d  = '0;
        end
      endcase
    end
  end

  assign deq_ready_o = !out_valid_q || out_o.ready;
  assign pop         = deq_valid_i && deq_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      wait_q      <= '0;
      held_q      <= '0;
      sel_q       <= 1'b0;
      step_q      <= STEP_IDLE;
      nib_q       <= '0;
      en_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        phase_q <= phase_d;
        wait_q  <= wait_d;
        held_q  <= held_d;
        sel_q   <= sel_d;
        step_q  <= step_d;
        nib_q   <= nib_d;
        en_q    <= en_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      rej_q  <= rej;
      busy_q <= (phase_d != PH_IDLE);
    end
  end

  // The pin levels of the last tick are the sequencer state itself.
  assign out_o.valid      = out_valid_q;
  assign out_o.reg_select = sel_q;
  assign out_o.read_write = 1'b0;
  assign out_o.enable     = en_q;
  assign out_o.bus_nibble = nib_q;
  assign out_o.busy_res   = busy_q;
  assign out_o.rejected   = rej_q;

endmodule

// File: design/lcd4_checker.sv
// ----------------------------------------------------------------------------
// LCD controller port checker
// Concurrent checks on the pin-state channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "char_lcd_4bit_write_controller_core_macros.svh"

module lcd4_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       reg_select_i,
  input logic       read_write_i,
  input logic       enable_i,
  input logic [3:0] bus_nibble_i,
  input logic       busy_res_i,
  input logic       rejected_i
);

  logic       stalled;
  logic [7:0] pin_bits;

  assign stalled  = out_valid_i && !out_ready_i;
  assign pin_bits = {reg_select_i, enable_i, bus_nibble_i, busy_res_i, rejected_i};

  // The display is only ever written, never read.
  `LCD4_ASSERT_NEVER(a_rw_low, out_valid_i && read_write_i, "RW driven high")

  // An enable strobe only happens inside a running sequence.
  `LCD4_ASSERT(a_en_busy, out_valid_i && enable_i |-> busy_res_i, "EN high while not busy")

  // Once idle, the enable line rests low.
  `LCD4_ASSERT(a_idle_en, out_valid_i && !busy_res_i |-> !enable_i, "EN high while idle")

  // A stalled result holds its value.
  `LCD4_ASSERT(a_hold, stalled |=> out_valid_i && $stable(pin_bits), "stalled result changed")

endmodule

bind char_lcd_4bit_write_controller_core lcd4_checker u_lcd4_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .reg_select_i (out_o.reg_select),
  .read_write_i (out_o.read_write),
  .enable_i     (out_o.enable),
  .bus_nibble_i (out_o.bus_nibble),
  .busy_res_i   (out_o.busy_res),
  .rejected_i   (out_o.rejected)
);

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the character LCD 4-bit write controller
// Drives ticks, init requests and byte writes into the request channel and
// checks every pin-state item against an item-by-item predictor of the pins.
// ----------------------------------------------------------------------------
module tb_top;
  import lcd4_pkg::*;

  // A run with no handshake on either channel for this many cycles is hung.
  // The longest legal quiet stretch is the deliberate receiver hold-off.
  localparam int unsigned StallLimit = 10000;
  localparam int unsigned HoldOffCycles = 300;
  // Mismatch lines stop being printed past this count; counting goes on.
  localparam int unsigned PrintLimit = 50;

  // An index past the last timing register; the block ignores writes to it.
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 3'd7;

  // Commands of the display setup, first command in the low byte.
  localparam logic [39:0] SETUP_CMDS = {8'h0F, 8'h06, 8'h01, 8'h08, 8'h28};

  // Phases of the pin sequencer as the predictor tracks them.
  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_POWER,
    SEQ_NIB_PULSE,
    SEQ_NIB_GAP,
    SEQ_HI_PULSE,
    SEQ_LO_SETUP,
    SEQ_LO_PULSE,
    SEQ_SETTLE,
    SEQ_INIT_GAP
  } seq_phase_e;

  // Pin levels and status for one tick.
  typedef struct packed {
    logic            rs;
    logic            rw;
    logic            en;
    logic [NibW-1:0] nib;
    logic            busy;
    logic            rej;
  } pins_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  lcd4_in_if  in_if ();
  lcd4_out_if out_if ();

  char_lcd_4bit_write_controller_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: timing registers and the sequencer as the block holds
  // them after the last accepted item.
  lcd4_cfg_t       lcd_cfg;
  seq_phase_e      seq_phase;
  logic [WaitW-1:0] seq_count;
  logic [ByteW-1:0] seq_byte;
  logic            seq_rs;
  logic [StepW-1:0] seq_step;
  logic [NibW-1:0] seq_nib;
  logic            seq_en;

  // Pin states predicted for accepted items, oldest first.
  pins_t pending_pins[$];

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold = 0;
  pins_t       want_pins;

  // ---------------------------------------------------------------------------
  // Predictor of the pin sequencer
  // ---------------------------------------------------------------------------

  // A phase lasting d ticks counts down from d-1; a zero register acts as one.
  function automatic logic [WaitW-1:0] reload_count(input logic [WaitW-1:0] d);
    return (d == '0) ? '0 : d - 1'b1;
  endfunction

  // The setup command for an init step, or zero outside the command steps.
  function automatic logic [ByteW-1:0] setup_cmd(input logic [StepW-1:0] step);
    int unsigned pos;
    pos = step - STEP_FIRST_CMD;
    if (step >= STEP_FIRST_CMD && step <= STEP_LAST_CMD) begin
      return SETUP_CMDS[8*pos +: 8];
    end
    return '0;
  endfunction

  // Entering a phase sets the pins it shows from its first tick and loads
  // the countdown for its length.
  function automatic void enter_phase(input seq_phase_e p);
    seq_phase = p;
    case (p)
      SEQ_POWER: begin
        seq_en = 1'b0;
        seq_nib = '0;
        seq_count = reload_count(WaitW'(lcd_cfg.power_up_ticks));
      end
      SEQ_NIB_PULSE: begin
        seq_nib = (seq_step == STEP_LAST_NIB) ? NIB_4BIT : NIB_WAKE;
        seq_en = 1'b1;
        seq_count = reload_count(WaitW'(lcd_cfg.pulse_ticks));
      end
      SEQ_NIB_GAP, SEQ_INIT_GAP: begin
        seq_en = 1'b0;
        seq_count = reload_count(WaitW'(lcd_cfg.init_gap_ticks));
      end
      SEQ_HI_PULSE: begin
        seq_nib = seq_byte[7:4];
        seq_en = 1'b1;
        seq_count = reload_count(WaitW'(lcd_cfg.pulse_ticks));
      end
      SEQ_LO_SETUP: begin
        // One tick with EN low and the low nibble already on the bus.
        seq_nib = seq_byte[3:0];
        seq_en = 1'b0;
        seq_count = '0;
      end
      SEQ_LO_PULSE: begin
        seq_en = 1'b1;
        seq_count = reload_count(WaitW'(lcd_cfg.pulse_ticks));
      end
      SEQ_SETTLE: begin
        seq_en = 1'b0;
        seq_count = reload_count(WaitW'(seq_rs ? lcd_cfg.data_wait_ticks
                                               : lcd_cfg.command_wait_ticks));
      end
      default: begin
        seq_phase = SEQ_IDLE;
        seq_en = 1'b0;
        seq_count = '0;
      end
    endcase
  endfunction

  // Moves on once the countdown of the current phase has run out.
  function automatic void next_phase();
    case (seq_phase)
      SEQ_POWER: begin
        seq_step = STEP_FIRST_NIB;
        enter_phase(SEQ_NIB_PULSE);
      end
      SEQ_NIB_PULSE: enter_phase(SEQ_NIB_GAP);
      SEQ_NIB_GAP: begin
        if (seq_step < STEP_LAST_NIB) begin
          seq_step = seq_step + 1'b1;
          enter_phase(SEQ_NIB_PULSE);
        end else begin
          seq_step = STEP_FIRST_CMD;
          seq_byte = setup_cmd(seq_step);
          seq_rs = 1'b0;
          enter_phase(SEQ_HI_PULSE);
        end
      end
      SEQ_HI_PULSE: enter_phase(SEQ_LO_SETUP);
      SEQ_LO_SETUP: enter_phase(SEQ_LO_PULSE);
      SEQ_LO_PULSE: enter_phase(SEQ_SETTLE);
      SEQ_SETTLE: begin
        // The last setup command ends in its settle time, with no gap after.
        if (seq_step >= STEP_FIRST_CMD && seq_step < STEP_LAST_CMD) begin
          enter_phase(SEQ_INIT_GAP);
        end else begin
          seq_step = STEP_IDLE;
          enter_phase(SEQ_IDLE);
        end
      end
      SEQ_INIT_GAP: begin
        seq_step = seq_step + 1'b1;
        seq_byte = setup_cmd(seq_step);
        enter_phase(SEQ_HI_PULSE);
      end
      default: begin
        seq_step = STEP_IDLE;
        enter_phase(SEQ_IDLE);
      end
    endcase
  endfunction

  // Advances the predictor by one accepted item and queues the pin state
  // that the block must report for it.
  function automatic void predict_pins(input lcd4_action_e act,
                                       input logic [ByteW-1:0] b);
    pins_t want;
    want.rej = 1'b0;
    if (seq_phase != SEQ_IDLE) begin
      // A request while busy is dropped, but the item still counts as a tick.
      if (act != ACT_TICK) want.rej = 1'b1;
      if (seq_count != '0) seq_count = seq_count - 1'b1;
      else next_phase();
    end else if (act == ACT_INIT) begin
      seq_rs = 1'b0;
      seq_step = STEP_IDLE;
      enter_phase(SEQ_POWER);
    end else if (act == ACT_CMD || act == ACT_DATA) begin
      // Byte writes need no prior init.
      seq_byte = b;
      seq_rs = (act == ACT_DATA);
      seq_step = STEP_IDLE;
      enter_phase(SEQ_HI_PULSE);
    end
    want.rs = seq_rs;
    want.rw = 1'b0;
    want.en = seq_en;
    want.nib = seq_nib;
    want.busy = (seq_phase != SEQ_IDLE);
    pending_pins.push_back(want);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    if (mismatches < PrintLimit) begin
      $display("tb_top: mismatch at %0t, result %0d: %s", $realtime, results_seen, what);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [NibW-1:0] got,
                             input logic [NibW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Every accepted pin-state item is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      results_seen++;
      if (pending_pins.size() == 0) begin
        report_mismatch("pin-state item arrived with nothing expected");
      end else begin
        want_pins = pending_pins.pop_front();
        check_field("RS", NibW'(out_if.reg_select), NibW'(want_pins.rs));
        check_field("RW", NibW'(out_if.read_write), NibW'(want_pins.rw));
        check_field("EN", NibW'(out_if.enable), NibW'(want_pins.en));
        check_field("DB7..DB4", out_if.bus_nibble, want_pins.nib);
        check_field("busy", NibW'(out_if.busy_res), NibW'(want_pins.busy));
        check_field("rejected", NibW'(out_if.rejected), NibW'(want_pins.rej));
      end
    end
  end

  // Watchdog: any handshake on either channel shows the run is still moving.
  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Receiver: stalls at random, or holds off completely while rx_hold runs.
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_if.ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers; every task starts and ends just after a falling edge.
  // ---------------------------------------------------------------------------

  // Offers one item, idling at random first, and returns once it is taken.
  // Valid stays high so that the next item can follow without a gap.
  task automatic offer_tick(input lcd4_action_e act, input logic [ByteW-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.action <= act;
    in_if.byte_value <= b;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    predict_pins(act, b);
    @(negedge clk_i);
  endtask

  // Ticks until the sequencer is back in idle. Some of the ticks may be
  // replaced by requests, which the block must reject.
  task automatic run_to_idle(input int unsigned noise_pct);
    while (seq_phase != SEQ_IDLE) begin
      if ($urandom_range(99) < noise_pct) begin
        offer_tick(lcd4_action_e'($urandom_range(3, 1)), ByteW'($urandom_range(255)));
      end else begin
        offer_tick(ACT_TICK, ByteW'($urandom_range(255)));
      end
    end
  endtask

  // Register writes happen only with nothing in flight. Each item yields a
  // result, so an empty queue plus a short pause leaves the pipeline empty.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] value);
    in_if.valid <= 1'b0;
    while (pending_pins.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PULSE:    lcd_cfg.pulse_ticks = value[PulseW-1:0];
      CFG_CMD_WAIT: lcd_cfg.command_wait_ticks = value[SettleW-1:0];
      CFG_DAT_WAIT: lcd_cfg.data_wait_ticks = value[SettleW-1:0];
      CFG_POWER_UP: lcd_cfg.power_up_ticks = value[PowerW-1:0];
      CFG_INIT_GAP: lcd_cfg.init_gap_ticks = value[GapW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [CfgDataW-1:0] pulse,
                            input logic [CfgDataW-1:0] cmd_wait,
                            input logic [CfgDataW-1:0] dat_wait,
                            input logic [CfgDataW-1:0] power_up,
                            input logic [CfgDataW-1:0] init_gap);
    write_reg(CFG_PULSE, pulse);
    write_reg(CFG_CMD_WAIT, cmd_wait);
    write_reg(CFG_DAT_WAIT, dat_wait);
    write_reg(CFG_POWER_UP, power_up);
    write_reg(CFG_INIT_GAP, init_gap);
  endtask

  // Short random durations keep sequences brief; zero and one show up often.
  function automatic logic [CfgDataW-1:0] short_ticks(input int unsigned longest);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 30) return CfgDataW'(1);
    return CfgDataW'($urandom_range(longest, 2));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A data write with the timing that reset leaves in the registers.
  task automatic test_reset_timing();
    offer_tick(ACT_DATA, 8'h41);
    run_to_idle(0);
  endtask

  // Hand-picked items: the full init with requests arriving during it, byte
  // extremes on both paths, requests right on the first idle tick, idle
  // ticks, a write to an unused index and registers written as zero.
  task automatic test_directed();
    set_timing(2, 3, 2, 3, 2);
    offer_tick(ACT_INIT, 8'h00);
    offer_tick(ACT_INIT, 8'hFF);
    offer_tick(ACT_CMD, 8'h55);
    offer_tick(ACT_DATA, 8'hAA);
    run_to_idle(0);
    offer_tick(ACT_CMD, 8'h00);
    run_to_idle(0);
    offer_tick(ACT_CMD, 8'hFF);
    run_to_idle(0);
    offer_tick(ACT_DATA, 8'h00);
    run_to_idle(0);
    offer_tick(ACT_DATA, 8'hFF);
    run_to_idle(0);
    offer_tick(ACT_DATA, 8'hA5);
    run_to_idle(0);
    offer_tick(ACT_CMD, 8'h5A);
    run_to_idle(0);
    offer_tick(ACT_TICK, 8'hFF);
    offer_tick(ACT_TICK, 8'h00);
    write_reg(CFG_SPARE, 20'hFFFFF);
    offer_tick(ACT_DATA, 8'h3C);
    run_to_idle(0);
    set_timing(0, 0, 0, 0, 0);
    offer_tick(ACT_INIT, 8'h00);
    run_to_idle(0);
    offer_tick(ACT_CMD, 8'h96);
    run_to_idle(0);
    offer_tick(ACT_DATA, 8'h69);
    run_to_idle(0);
  endtask

  // The receiver holds off for a long stretch while items keep coming, so
  // the block fills up and must stall its input without losing anything.
  task automatic test_backpressure();
    set_timing(2, 3, 2, 3, 2);
    rx_hold = HoldOffCycles;
    repeat (6) begin
      offer_tick(ACT_DATA, ByteW'($urandom_range(255)));
      run_to_idle(10);
    end
  endtask

  // Random timing, then mostly well-formed traffic: requests while idle and
  // ticks while busy, with a few requests thrown in while busy.
  task automatic test_random(input int unsigned count);
    lcd4_action_e act;
    int unsigned  pick;
    set_timing(short_ticks(4), short_ticks(6), short_ticks(6), short_ticks(8),
               short_ticks(6));
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (seq_phase == SEQ_IDLE) begin
        if (pick < 25) act = ACT_TICK;
        else if (pick < 40) act = ACT_INIT;
        else if (pick < 70) act = ACT_CMD;
        else act = ACT_DATA;
      end else begin
        act = (pick < 8) ? lcd4_action_e'($urandom_range(3, 1)) : ACT_TICK;
      end
      offer_tick(act, ByteW'($urandom_range(255)));
    end
    run_to_idle(0);
  endtask

  // Smallest and largest register values. A sequence at the largest values
  // runs for tens of thousands of ticks, so only its start is followed,
  // with a request that must be rejected on the way.
  task automatic test_extremes();
    set_timing(1, 1, 1, 1, 1);
    offer_tick(ACT_INIT, 8'h00);
    run_to_idle(0);
    set_timing(20'h003FF, 20'h0FFFF, 20'h0FFFF, 20'hFFFFF, 20'h0FFFF);
    offer_tick(ACT_CMD, 8'hC3);
    repeat (20) offer_tick(ACT_TICK, 8'h00);
    offer_tick(ACT_DATA, 8'h3C);
    repeat (20) offer_tick(ACT_TICK, 8'hFF);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.action = ACT_TICK;
    in_if.byte_value = '0;
    out_if.ready = 1'b0;

    lcd_cfg.pulse_ticks = RST_PULSE;
    lcd_cfg.command_wait_ticks = RST_CMD_WAIT;
    lcd_cfg.data_wait_ticks = RST_DAT_WAIT;
    lcd_cfg.power_up_ticks = RST_POWER_UP;
    lcd_cfg.init_gap_ticks = RST_INIT_GAP;
    seq_phase = SEQ_IDLE;
    seq_count = '0;
    seq_byte = '0;
    seq_rs = 1'b0;
    seq_step = STEP_IDLE;
    seq_nib = '0;
    seq_en = 1'b0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Sender mostly busy, receiver mostly stalling.
    tx_idle_pct = 25;
    rx_idle_pct = 88;
    test_reset_timing();
    test_directed();
    test_backpressure();
    test_random(230);

    // Sender mostly idle, receiver mostly ready.
    tx_idle_pct = 88;
    rx_idle_pct = 25;
    test_random(230);

    // Full rate on both sides.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(230);
    test_extremes();

    // Drain, then give the block time to show any stray extra item.
    in_if.valid <= 1'b0;
    while (pending_pins.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/lcd4_pkg.sv
design/lcd4_in_if.sv
design/lcd4_out_if.sv
design/lcd4_front.sv
design/lcd4_back.sv
design/char_lcd_4bit_write_controller_core.sv
design/lcd4_checker.sv
verif/tb_top.sv
